// ===== rtl/cclk_pkg.sv =====
// cclk_pkg: shared types, constants and helper functions for the calendar clock
// holds field widths, carry limits, the month length table and the leap-year test
// no dependencies
package cclk_pkg;

    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 16;

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 48;

    localparam logic [SEC_W:0]   SEC_LIMIT   = 7'd60;
    localparam logic [MIN_W:0]   MIN_LIMIT   = 7'd60;
    localparam logic [HOUR_W:0]  HOUR_LIMIT  = 6'd24;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;

    localparam logic [SEC_W-1:0]   RST_SEC   = 6'd0;
    localparam logic [MIN_W-1:0]   RST_MIN   = 6'd0;
    localparam logic [HOUR_W-1:0]  RST_HOUR  = 5'd0;
    localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RST_YEAR  = 16'd1970;

    // multiplicative inverse of 25 modulo 2^16 and the divisibility bound
    localparam logic [YEAR_W-1:0] INV25     = 16'h5C29;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } func_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } stamp_t;

    // gregorian leap test: div by 4 and not by 100, or div by 400
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_MAX);
        return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
    endfunction

    // invalid months count as 31 days
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/calendar_clock_leap_year.sv =====
// calendar_clock_leap_year: real-time clock calendar with gregorian leap years
// time/date counters, one-pass carry logic and a two-entry output buffer
// depends on cclk_pkg
//
//  channel | dir | tdata (low bit up)                              | tuser
//  --------+-----+-------------------------------------------------+-----------
//  s_      | in  | set_second, set_minute, set_hour, set_day,      | func
//          |     | set_month, set_year (42 bits, zero fill to 48)  |
//  m_      | out | second, minute, hour, day, month_now, year_now, | none
//          |     | leap_year (43 bits, zero fill to 48)            |
//
// one request per clock while s_tready is high; each result is registered
// the counters update in the accepting cycle through the carry chain
// second -> minute -> hour -> day -> month -> year, so back to back requests chain
// reset (aresetn low, synchronous) gives 00:00:00, day 1, month 1, year 1970
// an output register plus a skid entry let one more request in while a result
// waits; s_tready drops only when both entries are full
module calendar_clock_leap_year
    import cclk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // set_second[5:0], set_minute[11:6], set_hour[16:12], set_day[21:17],
    // set_month[25:22], set_year[41:26], zero [47:42]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func[0]: 0 = one-second tick, 1 = load
    input  logic                 s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // second[5:0], minute[11:6], hour[16:12], day[21:17], month_now[25:22],
    // year_now[41:26], leap_year[42], zero [47:43]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned STAMP_W = $bits(stamp_t);

    // current calendar state
    stamp_t cur_reg, cur_next;
    logic   leap_reg, leap_next;

    // output buffer
    logic [STAMP_W:0] out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    logic   push, pop;
    stamp_t load_stamp;
    func_t  func;

    // carry chain signals
    logic [SEC_W:0]    sec_inc;
    logic [MIN_W:0]    min_inc;
    logic [HOUR_W:0]   hour_inc;
    logic [DAY_W:0]    day_inc;
    logic [MONTH_W:0]  month_inc;
    logic [YEAR_W-1:0] year_inc;
    logic              sec_carry, min_carry, hour_carry, day_wrap, month_wrap;
    logic              leap_of_inc, leap_of_set;
    stamp_t            tick_stamp;

    assign func       = func_t'(s_tuser);
    assign load_stamp = stamp_t'(s_tdata[STAMP_W-1:0]);
    assign s_tready   = !skid_valid_reg;
    assign push       = s_tvalid && s_tready;
    assign pop        = out_valid_reg && m_tready;

    // one-second advance with carries
    always_comb begin
        sec_inc    = {1'b0, cur_reg.second} + 1'b1;
        min_inc    = {1'b0, cur_reg.minute} + 1'b1;
        hour_inc   = {1'b0, cur_reg.hour} + 1'b1;
        day_inc    = {1'b0, cur_reg.day} + 1'b1;
        month_inc  = {1'b0, cur_reg.month} + 1'b1;
        year_inc   = cur_reg.year + 1'b1;

        sec_carry  = (sec_inc >= SEC_LIMIT);
        min_carry  = sec_carry && (min_inc >= MIN_LIMIT);
        hour_carry = min_carry && (hour_inc >= HOUR_LIMIT);
        // day rolls only when it passes the month length
        day_wrap   = hour_carry &&
                     (day_inc > {1'b0, month_length(cur_reg.month, leap_reg)});
        // month zero or at/over december goes to january of the next year
        month_wrap = day_wrap &&
                     ((cur_reg.month == '0) || (month_inc > {1'b0, MONTH_LAST}));

        tick_stamp = cur_reg;
        if (!sec_carry) begin
            tick_stamp.second = sec_inc[SEC_W-1:0];
        end else begin
            tick_stamp.second = '0;
            if (!min_carry) begin
                tick_stamp.minute = min_inc[MIN_W-1:0];
            end else begin
                tick_stamp.minute = '0;
                if (!hour_carry) begin
                    tick_stamp.hour = hour_inc[HOUR_W-1:0];
                end else begin
                    tick_stamp.hour = '0;
                    if (!day_wrap) begin
                        tick_stamp.day = day_inc[DAY_W-1:0];
                    end else begin
                        tick_stamp.day = RST_DAY;
                        if (!month_wrap) begin
                            tick_stamp.month = month_inc[MONTH_W-1:0];
                        end else begin
                            tick_stamp.month = RST_MONTH;
                            tick_stamp.year  = year_inc;
                        end
                    end
                end
            end
        end

        // leap flag for the possible next years, computed side by side
        leap_of_inc = is_leap(year_inc);
        leap_of_set = is_leap(load_stamp.year);

        cur_next  = cur_reg;
        leap_next = leap_reg;
        if (push) begin
            unique case (func)
                FUNC_LOAD: begin
                    cur_next  = load_stamp;
                    leap_next = leap_of_set;
                end
                FUNC_TICK: begin
                    cur_next  = tick_stamp;
                    leap_next = month_wrap ? leap_of_inc : leap_reg;
                end
                default: begin
                    cur_next  = cur_reg;
                    leap_next = leap_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '{year: RST_YEAR, month: RST_MONTH, day: RST_DAY,
                          hour: RST_HOUR, minute: RST_MIN, second: RST_SEC};
            leap_reg <= 1'b0;
        end else begin
            cur_reg  <= cur_next;
            leap_reg <= leap_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (!out_valid_reg || pop) begin
                out_valid_reg <= push;
                if (push) begin
                    out_reg <= {leap_next, cur_next};
                end
            end else if (push) begin
                skid_reg       <= {leap_next, cur_next};
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - STAMP_W - 1){1'b0}}, out_reg};

endmodule
